### hw/rtl/assert_macros.svh
// Assertion macros for the box/plane contact generator RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### hw/rtl/bpcg_pkg.sv
// Types and constants for the box/plane contact generator.
// No dependencies.
package bpcg_pkg;
	localparam int PW = 20;
	localparam int DOTW = 35;
	localparam int BW = 53;
	localparam int DEPW = 56;
	localparam int POSW = 40;

	typedef struct packed {
		logic [59:0] pos;
		logic [47:0] nrm;
		logic [19:0] depth;
		logic [1:0]  idx;
		logic        last;
		logic [15:0] mat;
	} contact_t;

	function automatic logic [PW-1:0] sat_pos(input logic signed [POSW-1:0] p);
		logic signed [POSW-15:0] q;
		q = p[POSW-1:14];
		if (q > 26'sd524287) return 20'h7FFFF;
		if (q < -26'sd524288) return 20'h80000;
		return q[PW-1:0];
	endfunction

	function automatic logic [19:0] sat_depth(input logic signed [DEPW-1:0] d);
		if (d[DEPW-2:28] > 27'd1048575) return 20'hFFFFF;
		return d[47:28];
	endfunction
endpackage

### hw/rtl/bpcg_emit.sv
// Output sequencer: holds one item's up to three contacts and sends one per cycle while out_ready is high.
// Depends on bpcg_pkg.
module bpcg_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_cnt,
	input  bpcg_pkg::contact_t  in_c0,
	input  bpcg_pkg::contact_t  in_c1,
	input  bpcg_pkg::contact_t  in_c2,
	output logic                out_valid,
	input  logic                out_ready,
	output bpcg_pkg::contact_t  out_c
);
	bpcg_pkg::contact_t c_q [3];
	logic [1:0] cnt_q;
	logic [1:0] pos_q;
	logic busy_q;
	logic fin;

	assign out_valid = busy_q;
	assign out_c = c_q[pos_q];
	assign fin = busy_q && out_ready && (pos_q == cnt_q - 2'd1);
	assign in_ready = !busy_q || fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q <= 2'd0;
			cnt_q <= 2'd1;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			pos_q <= 2'd0;
			cnt_q <= in_cnt;
		end else if (fin) begin
			busy_q <= 1'b0;
		end else if (busy_q && out_ready) begin
			pos_q <= pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			c_q[0] <= in_c0;
			c_q[1] <= in_c1;
			c_q[2] <= in_c2;
		end
	end
endmodule

### hw/rtl/box_plane_contact_gen_core.sv
// Box/plane contact generator, top level. Four pipeline stages (dots, products,
// depth/sort, positions), then a contact sequencer. Contacts are registered in
// the sequencer after stage 4; one contact per cycle while m_axis_tready is high,
// 1..3 contacts per item. Items with no contact are dropped. A stalled output holds
// the whole pipeline. arst_n clears valid bits; max_contacts resets to 3.
// Depends on bpcg_pkg, bpcg_emit and assert_macros.svh.
`include "assert_macros.svh"
module box_plane_contact_gen_core #(
	parameter int MAX_CONTACT_LIMIT = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: box_axis_x, box_axis_y, box_axis_z, box_center, box_half_sizes,
	// plane_normal, plane_dist, material (lowest first), 336 bits
	input  logic [335:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: contact_pos, contact_normal, contact_depth, contact_index,
	// contact_material (lowest first), 152 bits (146 used)
	output logic [151:0] m_axis_tdata,
	// tlast: last_contact
	output logic         m_axis_tlast
);
	localparam int DOTW = bpcg_pkg::DOTW;
	localparam int BW = bpcg_pkg::BW;
	localparam int DEPW = bpcg_pkg::DEPW;
	localparam int POSW = bpcg_pkg::POSW;

	logic [1:0] maxc_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) maxc_q <= 2'd3;
		else if (cfg_we) maxc_q <= cfg_wdata;
	end

	logic [1:0] lim;
	always_comb begin
		lim = (maxc_q == 2'd0) ? 2'd1 : maxc_q;
		if (lim > 2'(MAX_CONTACT_LIMIT)) lim = 2'(MAX_CONTACT_LIMIT);
	end

	logic adv;
	logic e_ready;
	logic v_s1, v_s2, v_s3, v_s4;
	assign adv = e_ready || !v_s4;
	assign s_axis_tready = adv;

	// stage 1: dot products, unpack
	logic signed [15:0] ax_s1 [3][3];
	logic signed [19:0] cen_s1 [3];
	logic [15:0] h_s1 [3];
	logic signed [15:0] n_s1 [3];
	logic signed [19:0] dist_s1;
	logic [15:0] mat_s1;
	logic signed [DOTW-1:0] dot_s1 [3];

	logic signed [15:0] ax_i [3][3];
	logic signed [15:0] n_i [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			n_i[k] = s_axis_tdata[252 + 16*k +: 16];
			for (int c = 0; c < 3; c++) ax_i[k][c] = s_axis_tdata[48*k + 16*c +: 16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				for (int c = 0; c < 3; c++) ax_s1[k][c] <= ax_i[k][c];
				cen_s1[k] <= s_axis_tdata[144 + 20*k +: 20];
				h_s1[k] <= s_axis_tdata[204 + 16*k +: 16];
				n_s1[k] <= n_i[k];
				dot_s1[k] <= DOTW'(n_i[0]*ax_i[k][0]) + DOTW'(n_i[1]*ax_i[k][1])
					+ DOTW'(n_i[2]*ax_i[k][2]);
			end
			dist_s1 <= s_axis_tdata[300 +: 20];
			mat_s1 <= s_axis_tdata[320 +: 16];
		end
	end

	// stage 2: 2*half*dot, half*axis
	logic signed [BW-1:0] b_s2 [3];
	logic sgn_s2 [3];
	logic signed [POSW-1:0] off_s2 [3][3];
	logic signed [19:0] cen_s2 [3];
	logic signed [15:0] n_s2 [3];
	logic signed [19:0] dist_s2;
	logic [15:0] mat_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [BW-1:0] hd;
				hd = BW'($signed({1'b0, h_s1[k]}) * dot_s1[k]) <<< 1;
				b_s2[k] <= hd[BW-1] ? -hd : hd;
				sgn_s2[k] <= (hd > 0) && (h_s1[k] != 16'd0);
				for (int c = 0; c < 3; c++)
					off_s2[k][c] <= POSW'($signed({1'b0, h_s1[k]}) * ax_s1[k][c]);
				cen_s2[k] <= cen_s1[k];
				n_s2[k] <= n_s1[k];
			end
			dist_s2 <= dist_s1;
			mat_s2 <= mat_s1;
		end
	end

	// stage 3: depth, corner position, edge order
	logic signed [DEPW-1:0] dep_s3;
	logic signed [POSW-1:0] p0_s3 [3];
	logic signed [POSW-1:0] off_s3 [3][3];
	logic sgn_s3 [3];
	logic signed [BW:0] bb_s3 [3];
	logic [1:0] o0_s3, o1_s3;
	logic [47:0] nrm_s3;
	logic [15:0] mat_s3;
	logic [1:0] o0, o1;
	logic signed [BW-1:0] bq [3];
	always_comb begin
		for (int k = 0; k < 3; k++) bq[k] = b_s2[k];
		if (bq[0] < bq[1]) begin
			if (bq[2] < bq[0]) begin o0 = 2'd2; o1 = 2'd0; end
			else begin o0 = 2'd0; o1 = (bq[1] < bq[2]) ? 2'd1 : 2'd2; end
		end else begin
			if (bq[2] < bq[1]) begin o0 = 2'd2; o1 = 2'd1; end
			else begin o0 = 2'd1; o1 = (bq[0] < bq[2]) ? 2'd0 : 2'd2; end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			// side = sum |A|/2
			dep_s3 <= ((DEPW'(b_s2[0]) + DEPW'(b_s2[1]) + DEPW'(b_s2[2])) >>> 1)
				- (DEPW'(dist_s2) <<< 28);
			for (int c = 0; c < 3; c++) begin
				logic signed [POSW-1:0] p;
				p = POSW'(cen_s2[c]) <<< 14;
				for (int k = 0; k < 3; k++)
					p = sgn_s2[k] ? p - off_s2[k][c] : p + off_s2[k][c];
				p0_s3[c] <= p;
				nrm_s3[16*c +: 16] <= (n_s2[c] == -16'sd32768) ? 16'sd32767 : -n_s2[c];
			end
			for (int k = 0; k < 3; k++) begin
				bb_s3[k] <= (BW+1)'(b_s2[k]);
				sgn_s3[k] <= sgn_s2[k];
				for (int c = 0; c < 3; c++) off_s3[k][c] <= off_s2[k][c];
			end
			o0_s3 <= o0;
			o1_s3 <= o1;
			mat_s3 <= mat_s2;
		end
	end

	// stage 4: extra contacts, each stepping from the corner along one edge
	bpcg_pkg::contact_t c0_s4, c1_s4, c2_s4;
	logic [1:0] cnt_s4;
	logic ok_s4;
	logic signed [DEPW-1:0] d1, d2;
	logic [1:0] cnt;
	logic signed [POSW-1:0] p1 [3];
	logic signed [POSW-1:0] p2 [3];
	always_comb begin
		d1 = dep_s3 - DEPW'(bb_s3[o0_s3]);
		d2 = d1 - DEPW'(bb_s3[o1_s3]);
		cnt = 2'd1;
		if (lim >= 2'd2 && !d1[DEPW-1]) begin
			cnt = 2'd2;
			if (lim >= 2'd3 && !d2[DEPW-1]) cnt = 2'd3;
		end
		for (int c = 0; c < 3; c++) begin
			logic signed [POSW-1:0] e0, e1;
			e0 = off_s3[o0_s3][c] <<< 1;
			e1 = off_s3[o1_s3][c] <<< 1;
			p1[c] = sgn_s3[o0_s3] ? p0_s3[c] + e0 : p0_s3[c] - e0;
			p2[c] = sgn_s3[o1_s3] ? p0_s3[c] + e1 : p0_s3[c] - e1;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3 && !dep_s3[DEPW-1];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			cnt_s4 <= cnt;
			ok_s4 <= 1'b1;
			c0_s4.nrm <= nrm_s3; c1_s4.nrm <= nrm_s3; c2_s4.nrm <= nrm_s3;
			c0_s4.mat <= mat_s3; c1_s4.mat <= mat_s3; c2_s4.mat <= mat_s3;
			c0_s4.idx <= 2'd0; c1_s4.idx <= 2'd1; c2_s4.idx <= 2'd2;
			c0_s4.last <= (cnt == 2'd1);
			c1_s4.last <= (cnt == 2'd2);
			c2_s4.last <= 1'b1;
			c0_s4.depth <= bpcg_pkg::sat_depth(dep_s3);
			c1_s4.depth <= bpcg_pkg::sat_depth(d1);
			c2_s4.depth <= bpcg_pkg::sat_depth(d2);
			for (int c = 0; c < 3; c++) begin
				c0_s4.pos[20*c +: 20] <= bpcg_pkg::sat_pos(p0_s3[c]);
				c1_s4.pos[20*c +: 20] <= bpcg_pkg::sat_pos(p1[c]);
				c2_s4.pos[20*c +: 20] <= bpcg_pkg::sat_pos(p2[c]);
			end
		end
	end

	bpcg_pkg::contact_t oc;
	bpcg_emit u_emit (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s4 && ok_s4), .in_ready(e_ready),
		.in_cnt(cnt_s4), .in_c0(c0_s4), .in_c1(c1_s4), .in_c2(c2_s4),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_c(oc)
	);
	assign m_axis_tdata = {6'd0, oc.mat, oc.idx, oc.depth, oc.nrm, oc.pos};
	assign m_axis_tlast = oc.last;

	`ASSERT_CLK(a_idx, clk, arst_n, m_axis_tvalid |-> (oc.idx <= 2'd2), "bad index")
	`ASSERT_CLK(a_hold, clk, arst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "dropped")
	`ASSERT_NEVER(a_lim, clk, arst_n, m_axis_tvalid && (oc.idx >= lim), "over limit")
endmodule
